@@ sv/hwc_pkg.sv @@
// Shared types, constants and helpers for the heartbeat wake coalescer.
`timescale 1ns / 1ps
package hwc_pkg;

  localparam int SLOTS     = 32;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W    = 5;
  localparam int MAX_WAKES = 32;
  localparam int CNT_W     = $clog2(MAX_WAKES + 1);
  localparam int Q_DEPTH   = 2;

  // input command codes
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_WAIT  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GROUP_MODE  = 3'd0;
  localparam logic [2:0] REG_NOOP_MODE   = 3'd1;
  localparam logic [2:0] REG_HB_INTERVAL = 3'd2;
  localparam logic [2:0] REG_DEF_MIN     = 3'd3;
  localparam logic [2:0] REG_DEF_MAX     = 3'd4;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_WAIT,
    OP_CLOSE,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_OD,
    B_WAKE,
    B_FLUSH
  } back_state_t;

  typedef struct packed {
    logic        group_mode;
    logic        noop_mode;
    logic [15:0] beat_period;
    logic [15:0] default_min_wait;
    logic [15:0] default_max_wait;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       now;
    logic [15:0]       mn;
    logic [15:0]       mx;
    logic              kw;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] mn;
    logic [15:0] mx;
  } slot_rec_t;

  typedef struct packed {
    logic              woke;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       waited;
    logic              last;
  } res_t;

  // now >= base + gap, summed without wrap
  function automatic logic reached(input logic [31:0] now, input logic [31:0] base,
                                   input logic [15:0] gap);
    reached = {1'b0, now} >= ({1'b0, base} + 33'(gap));
  endfunction

endpackage

@@ sv/heartbeat_wake_coalescer.sv @@
// Top level: configuration registers, front end, executor and result queue.
`timescale 1ns / 1ps
// Heartbeat wake coalescer. Clients open a slot, post a wait window for it and close it;
// tick words carry the current time and scan the slot table, waking due sleepers.
// Input channel: a word is taken on a rising edge with push high and full low.
// Result channel: the oldest result sits on woke/woken_slot/waited/last while empty is
// low and leaves on a rising edge with pop high. Every input word yields one or more
// results; last marks the final one. Open, wait and close yield a single acknowledge.
// With the executor idle and the result queue not full, an acknowledge is registered
// in the command queue, then pushed by the executor into the result queue, where it
// shows on the result ports and can be popped. Open, wait and close run straight from
// the idle state, as does a tick with no open slot. Any other tick walks the slot
// table through its single registered read port, one slot a cycle unless a wake finds
// the result queue full: a start, a scan and a closing word in group and no-op modes,
// with a first pass in the default mode that records which waiting slots are overdue.
// A two-word command queue and a two-word result queue sit on either side of the
// executor, so input keeps flowing while results wait to be popped. When the receiver
// stalls, the result queue fills and the scan holds on the slot it is deciding.
// Reset (rst, synchronous) closes all slots, empties both queues and loads the
// register defaults. Write cfg_* only while the block is idle.
module heartbeat_wake_coalescer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [4:0]  slot,
  input  logic [31:0] time_now,
  input  logic [15:0] min_wait,
  input  logic [15:0] max_wait,
  input  logic        net_wake,
  output logic        empty,
  input  logic        pop,
  output logic        woke,
  output logic [4:0]  woken_slot,
  output logic [31:0] waited,
  output logic        last,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import hwc_pkg::*;

  cfg_t cfg;
  logic cq_valid;
  cmd_t cq_word;
  logic cq_pop;
  logic rq_full;
  logic rq_push;
  res_t rq_word;
  res_t head;

  // configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_mode       <= 1'b0;
      cfg.noop_mode        <= 1'b0;
      cfg.beat_period      <= 16'd30;
      cfg.default_min_wait <= 16'd27;
      cfg.default_max_wait <= 16'd30;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_GROUP_MODE:  cfg.group_mode       <= cfg_wdata[0];
        REG_NOOP_MODE:   cfg.noop_mode        <= cfg_wdata[0];
        REG_HB_INTERVAL: cfg.beat_period      <= cfg_wdata;
        REG_DEF_MIN:     cfg.default_min_wait <= cfg_wdata;
        REG_DEF_MAX:     cfg.default_max_wait <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // classify incoming words and queue them
  hwc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .slot          (slot),
    .time_now      (time_now),
    .min_wait      (min_wait),
    .max_wait      (max_wait),
    .net_wake      (net_wake),
    .cfg           (cfg),
    .cq_valid      (cq_valid),
    .cq_word       (cq_word),
    .cq_pop        (cq_pop)
  );

  // execute commands and run the tick scan
  hwc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cq_valid (cq_valid),
    .cq_word  (cq_word),
    .cq_pop   (cq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_word  (rq_word)
  );

  // hold results until the receiver pops them
  hwc_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .rq_push (rq_push),
    .rq_word (rq_word),
    .rq_full (rq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign woke       = head.woke;
  assign woken_slot = head.slot;
  assign waited     = head.waited;
  assign last       = head.last;

  // executor never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) rq_push |-> !rq_full)
    else $error("result pushed into full queue");

  // executor only takes commands that are queued
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) cq_pop |-> cq_valid)
    else $error("command popped from empty queue");

  // an acknowledge is always a closing word with cleared payload
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
      (!empty && !woke) |-> (last && woken_slot == 5'd0 && waited == 32'd0))
    else $error("malformed acknowledge");

endmodule

@@ sv/hwc_front.sv @@
// Front end: accept and classify input words into a short command queue.
`timescale 1ns / 1ps
module hwc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd,
  input  logic [hwc_pkg::SLOT_W-1:0] slot,
  input  logic [31:0]               time_now,
  input  logic [15:0]               min_wait,
  input  logic [15:0]               max_wait,
  input  logic                      net_wake,
  input  hwc_pkg::cfg_t             cfg,
  output logic                      cq_valid,
  output hwc_pkg::cmd_t             cq_word,
  input  logic                      cq_pop
);
  import hwc_pkg::*;

  cmd_t       q [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       accept;

  assign full     = (count == 2'(Q_DEPTH));
  assign cq_valid = (count != 2'd0);
  assign cq_word  = q[rd_ptr];
  assign accept   = push && !full;

  always_comb begin
    cls.slot = slot;
    cls.now  = time_now;
    cls.kw   = net_wake;
    // zero window takes the defaults
    if (min_wait == 16'd0 && max_wait == 16'd0) begin
      cls.mn = cfg.default_min_wait;
      cls.mx = cfg.default_max_wait;
    end else begin
      cls.mn = min_wait;
      cls.mx = max_wait;
    end
    if (cmd == CMD_TICK) begin
      cls.op = OP_TICK;
    end else if (int'(slot) >= SLOTS) begin
      cls.op = OP_NOP;
    end else begin
      case (cmd)
        CMD_OPEN:  cls.op = OP_OPEN;
        CMD_WAIT:  cls.op = OP_WAIT;
        CMD_CLOSE: cls.op = OP_CLOSE;
        default:   cls.op = OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cq_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(cq_pop);
    end
  end

endmodule

@@ sv/hwc_resq.sv @@
// Result queue: two-entry FIFO between the executor and the result ports.
`timescale 1ns / 1ps
module hwc_resq (
  input  logic          clk,
  input  logic          rst,
  input  logic          rq_push,
  input  hwc_pkg::res_t rq_word,
  output logic          rq_full,
  output logic          empty,
  input  logic          pop,
  output hwc_pkg::res_t head
);
  import hwc_pkg::*;

  res_t       q [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign rq_full = (count == 2'(Q_DEPTH));
  assign empty   = (count == 2'd0);
  assign head    = q[rd_ptr];
  assign take    = pop && !empty;

  always_ff @(posedge clk) begin
    if (rq_push) begin
      q[wr_ptr] <= rq_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (rq_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(rq_push) - 2'(take);
    end
  end

endmodule

@@ sv/hwc_back.sv @@
// Back end: slot table, command execution and the tick scan sequencer.
`timescale 1ns / 1ps
module hwc_back (
  input  logic          clk,
  input  logic          rst,
  input  hwc_pkg::cfg_t cfg,
  input  logic          cq_valid,
  input  hwc_pkg::cmd_t cq_word,
  output logic          cq_pop,
  input  logic          rq_full,
  output logic          rq_push,
  output hwc_pkg::res_t rq_word
);
  import hwc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  back_state_t      state, state_next;
  slot_rec_t        mem [SLOTS];
  slot_rec_t        rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] idx;
  logic [SLOTS-1:0] present;
  logic [SLOTS-1:0] waiting;
  logic [SLOTS-1:0] od_vec;
  logic [31:0]      tick_now;
  logic             tick_kw;
  logic             have_od;
  logic             od;
  logic             any_woken;
  logic [CNT_W-1:0] cnt;
  logic             pend_valid;
  res_t             pend;
  logic             all_wake;
  logic [31:0]      last_wake_time;

  logic             mode_noop, mode_group, mode_dflt;
  logic [IDX_W-1:0] cmd_idx;
  logic             tick_go, exec_go;
  logic             min_ok, max_ok, mn_zero, early, od_live, od_use, cond, hit;
  logic             od_latch, cap, wake_go;
  logic             all_wake_now;
  res_t             ack;

  assign mode_noop  = cfg.noop_mode;
  assign mode_group = cfg.group_mode && !cfg.noop_mode;
  assign mode_dflt  = !cfg.group_mode && !cfg.noop_mode;
  assign cmd_idx    = IDX_W'(cq_word.slot);
  assign ack        = '{woke: 1'b0, slot: '0, waited: '0, last: 1'b1};

  assign all_wake_now = mode_group &&
      (reached(cq_word.now, last_wake_time, cfg.beat_period) ||
       (cq_word.kw && reached(cq_word.now, last_wake_time, cfg.default_min_wait)));

  // per-slot wake decision on the registered table entry
  always_comb begin
    min_ok  = reached(tick_now, rd_data.start, rd_data.mn);
    max_ok  = reached(tick_now, rd_data.start, rd_data.mx);
    mn_zero = (rd_data.mn == 16'd0);
    early   = (any_woken && mn_zero) || (tick_kw && !mn_zero && min_ok);
    od_live = |(od_vec & waiting);
    od_use  = have_od ? od : od_live;
    if (mode_noop) begin
      cond = max_ok;
    end else if (mode_group) begin
      cond = all_wake;
    end else begin
      cond = early || max_ok || (od_use && !mn_zero && min_ok);
    end
    hit      = waiting[idx] && cond;
    od_latch = mode_dflt && waiting[idx] && !early && !max_ok && !have_od;
    cap      = (cnt == CNT_W'(MAX_WAKES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cq_pop     = 1'b0;
    rq_push    = 1'b0;
    rq_word    = ack;
    rd_addr    = idx;
    tick_go    = 1'b0;
    exec_go    = 1'b0;
    wake_go    = 1'b0;
    case (state)
      B_IDLE: begin
        if (cq_valid) begin
          if (cq_word.op == OP_TICK && |present) begin
            cq_pop     = 1'b1;
            tick_go    = 1'b1;
            rd_addr    = '0;
            state_next = mode_dflt ? B_OD : B_WAKE;
          end else if (!rq_full) begin
            cq_pop  = 1'b1;
            exec_go = 1'b1;
            rq_push = 1'b1;
          end
        end
      end
      B_OD: begin
        if (idx == LAST_IDX) begin
          rd_addr    = '0;
          state_next = B_WAKE;
        end else begin
          rd_addr = idx + 1'b1;
        end
      end
      B_WAKE: begin
        if (cap) begin
          state_next = B_FLUSH;
        end else if (!(hit && pend_valid && rq_full)) begin
          wake_go = 1'b1;
          if (hit && pend_valid) begin
            rq_push = 1'b1;
            rq_word = pend;
          end
          if (idx == LAST_IDX) begin
            state_next = B_FLUSH;
          end else begin
            rd_addr = idx + 1'b1;
          end
        end
      end
      B_FLUSH: begin
        if (!rq_full) begin
          rq_push    = 1'b1;
          rq_word    = pend_valid ? pend : ack;
          rq_word.last = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (exec_go && cq_word.op == OP_WAIT && present[cmd_idx]) begin
      mem[cmd_idx] <= '{start: cq_word.now, mn: cq_word.mn, mx: cq_word.mx};
    end
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      present        <= '0;
      waiting        <= '0;
      pend_valid     <= 1'b0;
      have_od        <= 1'b0;
      any_woken      <= 1'b0;
      all_wake       <= 1'b0;
      cnt            <= '0;
      last_wake_time <= '0;
    end else begin
      if (exec_go) begin
        case (cq_word.op)
          OP_OPEN: begin
            present[cmd_idx] <= 1'b1;
            waiting[cmd_idx] <= 1'b0;
          end
          OP_WAIT: begin
            if (present[cmd_idx]) begin
              waiting[cmd_idx] <= 1'b1;
            end
          end
          OP_CLOSE: begin
            present[cmd_idx] <= 1'b0;
            waiting[cmd_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (tick_go) begin
        have_od    <= 1'b0;
        any_woken  <= 1'b0;
        cnt        <= '0;
        pend_valid <= 1'b0;
        all_wake   <= all_wake_now;
        if (all_wake_now) begin
          last_wake_time <= cq_word.now;
        end
      end
      if (state == B_WAKE && !cap && od_latch) begin
        have_od <= 1'b1;
      end
      if (wake_go && hit) begin
        waiting[idx] <= 1'b0;
        pend_valid   <= 1'b1;
        any_woken    <= 1'b1;
        cnt          <= cnt + 1'b1;
      end
      if (state == B_FLUSH && !rq_full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (tick_go) begin
      tick_now <= cq_word.now;
      tick_kw  <= cq_word.kw;
      idx      <= '0;
    end
    if (state == B_OD) begin
      od_vec[idx] <= waiting[idx] && max_ok;
      idx         <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
    end
    if (state == B_WAKE && !cap && od_latch) begin
      od <= od_live;
    end
    if (wake_go) begin
      idx <= idx + 1'b1;
      if (hit) begin
        pend <= '{woke: 1'b1, slot: SLOT_W'(idx), waited: tick_now - rd_data.start,
                  last: 1'b0};
      end
    end
  end

endmodule

@@ dv/tb_heartbeat_wake_coalescer.sv @@
// Self-checking testbench for the heartbeat wake coalescer: directed words, then random phases.
`timescale 1ns / 1ps
module tb_heartbeat_wake_coalescer;
  import hwc_pkg::*;

  // Block ports
  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  cmd;
  logic [4:0]  slot;
  logic [31:0] time_now;
  logic [15:0] min_wait;
  logic [15:0] max_wait;
  logic        net_wake;
  logic        empty;
  logic        pop = 1'b0;
  logic        woke;
  logic [4:0]  woken_slot;
  logic [31:0] waited;
  logic        last;
  logic        cfg_wen;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  heartbeat_wake_coalescer i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .slot          (slot),
    .time_now      (time_now),
    .min_wait      (min_wait),
    .max_wait      (max_wait),
    .net_wake      (net_wake),
    .empty         (empty),
    .pop           (pop),
    .woke          (woke),
    .woken_slot    (woken_slot),
    .waited        (waited),
    .last          (last),
    .cfg_wen       (cfg_wen),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  // One directed word; when known is set the expected result is typed in by hand
  // and the predicted one is dropped.
  typedef struct packed {
    logic [1:0]  c;
    logic [4:0]  sl;
    logic [31:0] t;
    logic [15:0] mn;
    logic [15:0] mx;
    logic        kw;
    logic        known;
    res_t        known_res;
  } plan_t;

  // Shadow of the registers and the slot table
  logic        sh_simple;
  logic        sh_noop;
  logic [15:0] sh_interval;
  logic [15:0] sh_def_min;
  logic [15:0] sh_def_max;
  logic        slot_open    [SLOTS];
  logic        slot_asleep  [SLOTS];
  logic [31:0] sleep_start  [SLOTS];
  logic [15:0] sleep_min    [SLOTS];
  logic [15:0] sleep_max    [SLOTS];
  logic [31:0] last_group_wake;

  res_t  word_results[$];     // results of the word being predicted
  res_t  awaited_results[$];  // results still due from the block, oldest first
  plan_t plan[$];

  int    mismatches    = 0;
  int    words_in      = 0;
  int    results_seen  = 0;
  int    wake_reports  = 0;
  int    settings_seen = 0;
  int    rx_hold       = 0;
  bit    no_idle       = 1'b0;
  logic [31:0] clock_s;
  res_t  want_res;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", awaited_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // now >= base + gap, with the sum kept in 33 bits so it cannot wrap
  function automatic bit at_or_past(logic [31:0] now_t, logic [31:0] base, logic [15:0] gap);
    return {1'b0, now_t} >= ({1'b0, base} + {17'd0, gap});
  endfunction

  function automatic bit any_overdue(logic [31:0] now_t);
    for (int i = 0; i < SLOTS; i++)
      if (slot_asleep[i] && at_or_past(now_t, sleep_start[i], sleep_max[i])) return 1'b1;
    return 1'b0;
  endfunction

  // Scan the table in index order and queue one wake report per slot that is due.
  function automatic void coalesce_tick(logic [31:0] now_t, logic kw);
    bit          any_open;
    bit          wake_all;
    bit          od_known;
    bit          od;
    bit          early;
    int          woken;
    logic [15:0] mn_i;
    res_t        rec;
    any_open = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_open[i]) any_open = 1'b1;
    if (!any_open) return;
    wake_all = 1'b0;
    if (sh_simple && !sh_noop) begin
      if (at_or_past(now_t, last_group_wake, sh_interval) ||
          (kw && at_or_past(now_t, last_group_wake, sh_def_min))) begin
        wake_all = 1'b1;
        last_group_wake = now_t;
      end
    end
    woken = 0;
    od_known = 1'b0;
    od = 1'b0;
    for (int i = 0; i < SLOTS && woken < MAX_WAKES; i++) begin
      if (!slot_asleep[i]) continue;
      if (sh_noop) begin
        if (!at_or_past(now_t, sleep_start[i], sleep_max[i])) continue;
      end else if (sh_simple) begin
        if (!wake_all) continue;
      end else begin
        mn_i = sleep_min[i];
        early = (woken > 0 && mn_i == 16'd0) ||
                (kw && mn_i != 16'd0 && at_or_past(now_t, sleep_start[i], mn_i));
        if (!early && !at_or_past(now_t, sleep_start[i], sleep_max[i])) begin
          // overdue flag is sampled once, at the first slot that needs it
          if (!od_known) begin
            od = any_overdue(now_t);
            od_known = 1'b1;
          end
          if (!od || mn_i == 16'd0) continue;
          if (!at_or_past(now_t, sleep_start[i], mn_i)) continue;
        end
      end
      slot_asleep[i] = 1'b0;
      rec = '0;
      rec.woke = 1'b1;
      rec.slot = 5'(i);
      rec.waited = now_t - sleep_start[i];
      word_results.push_back(rec);
      woken++;
    end
  endfunction

  // Advance the shadow table by one word and collect its results, last flag set.
  function automatic void predict_word(logic [1:0] c, logic [4:0] sl, logic [31:0] t,
                                       logic [15:0] mn, logic [15:0] mx, logic kw);
    res_t rec;
    word_results.delete();
    case (c)
      CMD_TICK: coalesce_tick(t, kw);
      CMD_OPEN: begin
        slot_open[sl] = 1'b1;
        slot_asleep[sl] = 1'b0;
      end
      CMD_WAIT: begin
        if (slot_open[sl]) begin
          if (mn == 16'd0 && mx == 16'd0) begin
            mn = sh_def_min;
            mx = sh_def_max;
          end
          sleep_start[sl] = t;
          sleep_min[sl] = mn;
          sleep_max[sl] = mx;
          slot_asleep[sl] = 1'b1;
        end
      end
      default: begin
        slot_open[sl] = 1'b0;
        slot_asleep[sl] = 1'b0;
      end
    endcase
    if (word_results.size() == 0) word_results.push_back('0);
    rec = word_results[word_results.size() - 1];
    rec.last = 1'b1;
    word_results[word_results.size() - 1] = rec;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one word, hold it until taken, then record what it should produce.
  task automatic send_word(input logic [1:0] c, input logic [4:0] sl, input logic [31:0] t,
                           input logic [15:0] mn, input logic [15:0] mx, input logic kw,
                           input logic known, input res_t known_res);
    int gap;
    push <= 1'b1;
    cmd <= c;
    slot <= sl;
    time_now <= t;
    min_wait <= mn;
    max_wait <= mx;
    net_wake <= kw;
    do @(posedge clk); while (full);
    words_in++;
    predict_word(c, sl, t, mn, mx, kw);
    if (known) awaited_results.push_back(known_res);
    else foreach (word_results[k]) awaited_results.push_back(word_results[k]);
    gap = no_idle ? 0 : idle_span();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every awaited result is out, then let the executor settle.
  task automatic drain_results();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic plan_word(input logic [1:0] c, input logic [4:0] sl, input logic [31:0] t,
                           input logic [15:0] mn, input logic [15:0] mx, input logic kw,
                           input logic known, input logic k_woke, input logic [4:0] k_slot,
                           input logic [31:0] k_waited);
    plan_t p;
    p.c = c;
    p.sl = sl;
    p.t = t;
    p.mn = mn;
    p.mx = mx;
    p.kw = kw;
    p.known = known;
    p.known_res.woke = k_woke;
    p.known_res.slot = k_slot;
    p.known_res.waited = k_waited;
    p.known_res.last = 1'b1;
    plan.push_back(p);
  endtask

  // One register setting followed by random well-formed traffic with some noise.
  task automatic random_phase(input logic sm, input logic nm, input logic [15:0] iv,
                              input logic [15:0] dmn, input logic [15:0] dmx,
                              input logic [31:0] t0, input bit steady);
    int          placed;
    int          pick;
    int          r;
    logic [1:0]  c;
    logic [4:0]  sl;
    logic [31:0] t;
    logic [15:0] mn;
    logic [15:0] mx;
    logic        kw;
    drain_results();
    write_reg(REG_GROUP_MODE, {15'd0, sm});
    write_reg(REG_NOOP_MODE, {15'd0, nm});
    write_reg(REG_HB_INTERVAL, iv);
    write_reg(REG_DEF_MIN, dmn);
    write_reg(REG_DEF_MAX, dmx);
    cfg_wen <= 1'b0;
    sh_simple = sm;
    sh_noop = nm;
    sh_interval = iv;
    sh_def_min = dmn;
    sh_def_max = dmx;
    settings_seen++;
    clock_s = t0;
    no_idle = steady;
    placed = 0;
    while (placed < 14) begin
      pick = $urandom_range(0, 99);
      // favor a few slots so they get opened, waited on and woken
      sl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
      t = $urandom;
      mn = 16'($urandom);
      mx = 16'($urandom);
      kw = 1'($urandom);
      if (pick < 18) begin
        c = CMD_OPEN;
      end else if (pick < 52) begin
        c = CMD_WAIT;
        if ($urandom_range(0, 9) != 0) t = clock_s;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          mn = 16'd0;
          mx = 16'd0;
        end else if (r >= 25) begin
          mn = (r < 45) ? 16'd0 : 16'($urandom_range(1, 15));
          mx = mn + 16'($urandom_range(0, 30));
        end
      end else if (pick < 60) begin
        c = CMD_CLOSE;
      end else begin
        c = CMD_TICK;
        r = $urandom_range(0, 99);
        if (r >= 6) begin
          clock_s = clock_s + ((r < 14) ? $urandom_range(0, 70000) : $urandom_range(0, 12));
          t = clock_s;
        end
        kw = ($urandom_range(0, 2) == 0);
      end
      placed++;
      send_word(c, sl, t, mn, mx, kw, 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  // Receiver: check every popped result against the oldest awaited one, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (woke === 1'b1) wake_reports++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: woke=%0d slot=%0d waited=%0d last=%0d",
                     woke, woken_slot, waited, last);
        end else begin
          want_res = awaited_results.pop_front();
          if (woke !== want_res.woke || woken_slot !== want_res.slot ||
              waited !== want_res.waited || last !== want_res.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch at %0t: expected woke=%0d slot=%0d waited=%0d last=%0d, ",
                        "got woke=%0d slot=%0d waited=%0d last=%0d"}, $time,
                       want_res.woke, want_res.slot, want_res.waited, want_res.last,
                       woke, woken_slot, waited, last);
          end
        end
      end
      if (no_idle) begin
        pop <= 1'b1;
      end else if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else begin
        pop <= 1'b1;
        rx_hold <= idle_span();
      end
    end
  end

  // Stimulus
  initial begin
    plan_t p;
    rst = 1'b1;
    push = 1'b0;
    cmd = CMD_OPEN;
    slot = '0;
    time_now = '0;
    min_wait = '0;
    max_wait = '0;
    net_wake = 1'b0;
    cfg_wen = 1'b0;
    cfg_idx = REG_GROUP_MODE;
    cfg_wdata = '0;
    // reset view of the block
    sh_simple = 1'b0;
    sh_noop = 1'b0;
    sh_interval = 16'd30;
    sh_def_min = 16'd27;
    sh_def_max = 16'd30;
    last_group_wake = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_open[i] = 1'b0;
      slot_asleep[i] = 1'b0;
      sleep_start[i] = '0;
      sleep_min[i] = '0;
      sleep_max[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset register values
    plan_word(CMD_TICK,  5'd0,  32'd100,  16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd3,  32'd5,    16'd1, 16'd2, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_CLOSE, 5'd4,  32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_OPEN,  5'd0,  32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_OPEN,  5'd31, 32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    // zero window: takes the default min and max
    plan_word(CMD_WAIT,  5'd0,  32'd1000, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd31, 32'd1000, 16'd5, 16'd10, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_TICK,  5'd0,  32'd1004, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    // network wake lets slot 31 go early once its min has passed
    plan_word(CMD_TICK,  5'd0,  32'd1006, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 5'd31, 32'd6);
    plan_word(CMD_OPEN,  5'd7,  32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd7,  32'd1040, 16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_OPEN,  5'd9,  32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd9,  32'd1040, 16'd10, 16'd200, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    // slot 0 is past max; slot 7 has no min and follows a wake
    plan_word(CMD_TICK,  5'd0,  32'd1045, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0);
    // repeated wait restarts the window
    plan_word(CMD_WAIT,  5'd9,  32'd1050, 16'd20, 16'd30, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd0,  32'd1050, 16'd40, 16'd100, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    // slot 9 overdue, but slot 0 has not reached its min yet
    plan_word(CMD_TICK,  5'd0,  32'd1081, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_WAIT,  5'd9,  32'd1090, 16'd1, 16'd2, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    // slot 9 overdue pulls slot 0 along once its min has passed
    plan_word(CMD_TICK,  5'd0,  32'd1100, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0);
    // window near the top of time: sums must not wrap
    plan_word(CMD_WAIT,  5'd31, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 1'b0,
              1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_TICK,  5'd0,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              1'b0, 1'b0, 5'd0, 32'd0);
    // reopen of a sleeping slot cancels its wait
    plan_word(CMD_OPEN,  5'd31, 32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_TICK,  5'd0,  32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0);
    plan_word(CMD_CLOSE, 5'd31, 32'd0,    16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 5'd0, 32'd0);
    foreach (plan[k]) begin
      p = plan[k];
      send_word(p.c, p.sl, p.t, p.mn, p.mx, p.kw, p.known, p.known_res);
    end

    // Random phases, each after a full drain and a fresh register setting
    random_phase(1'b0, 1'b0, 16'd30,    16'd27,    16'd30,    32'd5000,      1'b0);
    random_phase(1'b0, 1'b1, 16'd3,     16'd0,     16'd0,     32'd20000,     1'b0);
    random_phase(1'b1, 1'b0, 16'd3,     16'hFFFF,  16'hFFFF,  32'd40000,     1'b1);
    random_phase(1'b1, 1'b0, 16'hFFFF,  16'd0,     16'd5,     32'd90000,     1'b0);
    random_phase(1'b1, 1'b1, 16'd100,   16'd10,    16'd20,    32'hFFFF_FF00, 1'b0);
    random_phase(1'b0, 1'b0, 16'hFFFF,  16'd0,     16'hFFFF,  32'hFFFF_FFC0, 1'b0);
    random_phase(1'b0, 1'b0, 16'd17,    16'd3,     16'd9,     32'd700000,    1'b0);

    drain_results();
    $display("Covered %0d input words over %0d register settings plus reset defaults;",
             words_in, settings_seen);
    $display("checked %0d results, %0d of them wake reports, %0d mismatching.",
             results_seen, wake_reports, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
